>>> rtl/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// Shared constants of the PWM tone setup timer: command codes, frequency
// clamp bounds, wrap search bounds, divider bounds and the clock reset value.
// ----------------------------------------------------------------------------
package pts_pkg;

  // Command codes carried by the command field.
  localparam logic [1:0] CMD_PLAY = 2'd0;
  localparam logic [1:0] CMD_OFF  = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  // Tone frequency clamp, in hertz.
  localparam logic [14:0] FREQ_MIN = 15'd20;
  localparam logic [14:0] FREQ_MAX = 15'd20000;

  // Wrap search: start value and the doubling limit.
  localparam logic [15:0] WRAP_START = 16'd1000;
  localparam logic [15:0] WRAP_LIMIT = 16'd32768;

  // Divider in unsigned 8.4 fixed point, clamped to 1.0 .. 255.875.
  localparam logic [11:0] DIV_FIX_MIN = 12'd16;
  localparam logic [11:0] DIV_FIX_MAX = 12'd4094;
  localparam logic [7:0]  DIV_MAX_WHOLE = 8'd255;

  // Reset value of the system clock register.
  localparam logic [27:0] SYSCLK_RESET = 28'd125000000;

endpackage

>>> rtl/pwm_tone_setup_timer.sv
// ----------------------------------------------------------------------------
// pwm_tone_setup_timer
// Tone generator setup: turns play, off and millisecond-tick commands into
// PWM wrap, clock divider and compare settings, with a timed shutoff.
// ----------------------------------------------------------------------------
// An off command, a tick, an unused code or a play at zero frequency goes
// straight from acceptance to the emit state, which loads the result register
// once it has room. A play at a real frequency passes through the multiply,
// scale, test, divide, finish and emit states; each wrap doubling (0 to 6 of
// them) passes through the scale and test states once more, and the divider
// is a restoring bit-serial divider that produces one quotient bit per cycle
// for a 13-bit quotient. One transaction is worked on at a time; the next one
// is accepted while the previous result waits in the output register.
module pwm_tone_setup_timer
  import pts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Configuration: system clock frequency in hertz.
  input  logic        cfg_wr_en,
  input  logic [27:0] cfg_wr_data,
  // Command channel.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [19:0] freq_hz,
  input  logic [23:0] tone_len_ms,
  // Result channel.
  output logic        out_valid,
  input  logic        out_ready,
  output logic        pwm_enabled,
  output logic        pin_is_pwm,
  output logic [15:0] wrap_value,
  output logic [7:0]  divider_int,
  output logic [3:0]  divider_frac,
  output logic [14:0] duty_level,
  output logic        tone_expired
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MULT,
    S_SCALE,
    S_TEST,
    S_DIV,
    S_FIN,
    S_EMIT
  } state_t;

  state_t      state;
  logic [27:0] sysclk_hz;

  // Architectural tone state.
  logic        running;
  logic        pin_pwm_mode;
  logic        started_once;
  logic [15:0] wrap_reg;
  logic [11:0] divider_fixed;
  logic [14:0] level_reg;
  logic [23:0] remaining_ms;
  logic        timer_armed;
  logic        expired;

  // Working registers of a play setup.
  logic [14:0] freq_r;
  logic [23:0] dur_r;
  logic [15:0] wrap_work;
  logic [30:0] prod;      // freq * (wrap + 1)
  logic [38:0] prod_x255; // 255 * freq * (wrap + 1)
  logic [31:0] rem_r;     // divider remainder
  logic [42:0] dsr;       // shifted divisor
  logic [12:0] quo;
  logic [3:0]  div_cnt;

  // Combinational helpers.
  logic [14:0] freq_clamped;
  logic [23:0] rem_dec;
  logic        do_double;
  logic        div_bit;
  logic [11:0] quo_clamped;
  logic        out_free;

  // Clamp the requested frequency into the audible range.
  always_comb begin
    priority if (freq_hz < {5'd0, FREQ_MIN}) begin
      freq_clamped = FREQ_MIN;
    end else if (freq_hz > {5'd0, FREQ_MAX}) begin
      freq_clamped = FREQ_MAX;
    end else begin
      freq_clamped = freq_hz[14:0];
    end
  end

  // Countdown step, doubling test, division step and divider clamp.
  always_comb begin
    rem_dec   = remaining_ms - {23'd0, (remaining_ms != 24'd0)};
    do_double = ({11'd0, sysclk_hz} > prod_x255) && (wrap_work < WRAP_LIMIT);
    div_bit   = ({11'd0, rem_r} >= dsr);
    priority if (quo[12]) begin
      quo_clamped = DIV_FIX_MAX;
    end else if (quo[11:0] < DIV_FIX_MIN) begin
      quo_clamped = DIV_FIX_MIN;
    end else if (quo[11:0] > DIV_FIX_MAX) begin
      quo_clamped = DIV_FIX_MAX;
    end else begin
      quo_clamped = quo[11:0];
    end
  end

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      sysclk_hz <= SYSCLK_RESET;
    end else if (cfg_wr_en) begin
      sysclk_hz <= cfg_wr_data;
    end
  end

  // Sequencer, tone state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      running       <= 1'b0;
      pin_pwm_mode  <= 1'b0;
      started_once  <= 1'b0;
      wrap_reg      <= WRAP_START;
      divider_fixed <= DIV_FIX_MIN;
      level_reg     <= WRAP_START[15:1];
      remaining_ms  <= 24'd0;
      timer_armed   <= 1'b0;
      expired       <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      // The result register empties when the transaction is taken, unless a
      // new result is loaded at the same edge.
      if (out_valid && out_ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            expired <= (command == CMD_TICK) && timer_armed && (rem_dec == 24'd0);
            if ((command == CMD_PLAY) && (freq_hz != 20'd0)) begin
              state <= S_MULT;
            end else begin
              state <= S_EMIT;
            end
            unique case (command)
              CMD_PLAY: begin
                started_once <= 1'b1;
                timer_armed  <= 1'b0;
                remaining_ms <= 24'd0;
                freq_r       <= freq_clamped;
                dur_r        <= tone_len_ms;
                wrap_work    <= WRAP_START;
                if (freq_hz == 20'd0) begin
                  running      <= 1'b0;
                  pin_pwm_mode <= 1'b0;
                end else begin
                  pin_pwm_mode <= 1'b1;
                end
              end
              CMD_OFF: begin
                if (started_once) begin
                  running      <= 1'b0;
                  pin_pwm_mode <= 1'b0;
                  timer_armed  <= 1'b0;
                  remaining_ms <= 24'd0;
                end
              end
              CMD_TICK: begin
                if (timer_armed) begin
                  remaining_ms <= rem_dec;
                  if (rem_dec == 24'd0) begin
                    timer_armed <= 1'b0;
                    if (started_once) begin
                      running      <= 1'b0;
                      pin_pwm_mode <= 1'b0;
                    end
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end

        // Product for the starting wrap.
        S_MULT: begin
          prod  <= 31'(freq_r) * 31'(WRAP_START + 16'd1);
          state <= S_SCALE;
        end

        // Scale the product by the largest whole divider.
        S_SCALE: begin
          prod_x255 <= 39'(prod) * 39'(DIV_MAX_WHOLE);
          state     <= S_TEST;
        end

        // Double the wrap while under its limit and the divider is above 255.
        S_TEST: begin
          if (do_double) begin
            wrap_work <= {wrap_work[14:0], 1'b0};
            prod      <= {prod[29:0], 1'b0} - 31'(freq_r);
            state     <= S_SCALE;
          end else begin
            rem_r   <= {sysclk_hz, 4'd0};
            dsr     <= {prod, 12'd0};
            quo     <= 13'd0;
            div_cnt <= 4'd12;
            state   <= S_DIV;
          end
        end

        // Restoring division, one quotient bit per cycle.
        S_DIV: begin
          if (div_bit) begin
            rem_r <= rem_r - dsr[31:0];
          end
          quo     <= {quo[11:0], div_bit};
          dsr     <= {1'b0, dsr[42:1]};
          div_cnt <= div_cnt - 4'd1;
          if (div_cnt == 4'd0) begin
            state <= S_FIN;
          end
        end

        // Commit the new tone settings.
        S_FIN: begin
          wrap_reg      <= wrap_work;
          divider_fixed <= quo_clamped;
          level_reg     <= wrap_work[15:1];
          running       <= 1'b1;
          if (dur_r != 24'd0) begin
            timer_armed  <= 1'b1;
            remaining_ms <= dur_r;
          end
          state <= S_EMIT;
        end

        // Hand the state to the output register once it has room.
        S_EMIT: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            pwm_enabled  <= running;
            pin_is_pwm   <= pin_pwm_mode;
            wrap_value   <= wrap_reg;
            divider_int  <= divider_fixed[11:4];
            divider_frac <= divider_fixed[3:0];
            duty_level   <= level_reg;
            tone_expired <= expired;
            state        <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/pts_checker.sv
// ----------------------------------------------------------------------------
// pts_checker
// Port-level checks of the PWM tone setup timer, bound to the top level.
// ----------------------------------------------------------------------------
module pts_checker
  import pts_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        pwm_enabled,
  input logic        pin_is_pwm,
  input logic [15:0] wrap_value,
  input logic [7:0]  divider_int,
  input logic [14:0] duty_level,
  input logic        tone_expired
);

  // A stalled result transaction stays valid and keeps its wrap and compare level.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(wrap_value) && $stable(duty_level))
    else $error("result changed while stalled");

  // A running tone always has the pin attached to the PWM.
  a_run_pin: assert property (@(posedge clk) disable iff (rst)
    out_valid && pwm_enabled |-> pin_is_pwm)
    else $error("PWM running with the pin parked");

  // The tick that ends a tone shows it stopped and parked.
  a_expired_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && tone_expired |-> !pwm_enabled && !pin_is_pwm)
    else $error("expired tone still running");

  // The compare level is half the wrap, and the wrap never shrinks
  // below its starting value.
  a_level: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> duty_level == wrap_value[15:1] && wrap_value >= WRAP_START)
    else $error("level does not match wrap");

  // The divider never falls below one.
  a_div_min: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> divider_int != 8'd0)
    else $error("divider below one");

endmodule

bind pwm_tone_setup_timer pts_checker u_pts_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .pwm_enabled  (pwm_enabled),
  .pin_is_pwm   (pin_is_pwm),
  .wrap_value   (wrap_value),
  .divider_int  (divider_int),
  .duty_level   (duty_level),
  .tone_expired (tone_expired)
);

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the PWM tone setup timer. Play, off and tick
// commands go in through a valid/ready channel, and a scoreboard class
// predicts each result: wrap, divider, compare level, run state and
// countdown expiry. The system clock register is swept through several
// values, extremes included, between quiet points. Both sides of the
// block idle in random bursts except in the last phase.
// ----------------------------------------------------------------------------
module tb_top;
  import pts_pkg::*;

  localparam logic [1:0]  CMD_UNUSED  = 2'd3;
  localparam int unsigned STALL_LIMIT = 4000;

  typedef struct packed {
    logic        pwm_enabled;
    logic        pin_is_pwm;
    logic [15:0] wrap_value;
    logic [7:0]  divider_int;
    logic [3:0]  divider_frac;
    logic [14:0] duty_level;
    logic        tone_expired;
  } tone_result_t;

  // Tone state predictor and queue of results still to come.
  class tone_scoreboard;
    logic [27:0]  sysclk_hz;
    bit           running;
    bit           pin_pwm;
    bit           started;
    bit           timer_armed;
    logic [15:0]  wrap_q;
    logic [11:0]  div_fixed;
    logic [15:0]  level_q;
    logic [23:0]  remaining_ms;
    tone_result_t expected_q[$];
    int unsigned  mismatches;

    function new();
      sysclk_hz    = SYSCLK_RESET;
      running      = 1'b0;
      pin_pwm      = 1'b0;
      started      = 1'b0;
      timer_armed  = 1'b0;
      wrap_q       = WRAP_START;
      div_fixed    = DIV_FIX_MIN;
      level_q      = 16'd500;
      remaining_ms = '0;
      mismatches   = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void cancel_countdown();
      timer_armed  = 1'b0;
      remaining_ms = '0;
    endfunction

    // Off has no effect until the first play has been seen.
    function void switch_off();
      if (started) begin
        running = 1'b0;
        pin_pwm = 1'b0;
        cancel_countdown();
      end
    endfunction

    function void start_tone(logic [19:0] freq, logic [23:0] dur);
      longint unsigned clk_hz;
      longint unsigned quotient;
      int unsigned     f;
      int unsigned     w;
      started = 1'b1;
      pin_pwm = 1'b1;
      cancel_countdown();
      if (freq == '0) begin
        switch_off();
        return;
      end
      f = 32'(freq);
      if (f < 32'(FREQ_MIN)) f = 32'(FREQ_MIN);
      if (f > 32'(FREQ_MAX)) f = 32'(FREQ_MAX);
      clk_hz = 64'(sysclk_hz);
      // Double the wrap until the divider is at most 255 or the wrap reaches its limit.
      w = 32'(WRAP_START);
      while (clk_hz > 64'(DIV_MAX_WHOLE) * 64'(f) * 64'(w + 1) && w < 32'(WRAP_LIMIT))
        w = w * 2;
      quotient = (clk_hz * 64'd16) / (64'(f) * 64'(w + 1));
      if (quotient < 64'(DIV_FIX_MIN)) quotient = 64'(DIV_FIX_MIN);
      if (quotient > 64'(DIV_FIX_MAX)) quotient = 64'(DIV_FIX_MAX);
      div_fixed = quotient[11:0];
      wrap_q    = w[15:0];
      level_q   = 16'((w + 1) / 2);
      running   = 1'b1;
      if (dur != '0) begin
        timer_armed  = 1'b1;
        remaining_ms = dur;
      end
    endfunction

    // Apply one accepted command and queue the result it must produce.
    function void note_command(logic [1:0] cmd, logic [19:0] freq, logic [23:0] dur);
      tone_result_t res;
      bit           expired;
      expired = 1'b0;
      case (cmd)
        CMD_PLAY: start_tone(freq, dur);
        CMD_OFF:  switch_off();
        CMD_TICK: begin
          if (timer_armed) begin
            if (remaining_ms != '0) remaining_ms--;
            if (remaining_ms == '0) begin
              timer_armed = 1'b0;
              switch_off();
              expired = 1'b1;
            end
          end
        end
        default: ;
      endcase
      res.pwm_enabled  = running;
      res.pin_is_pwm   = pin_pwm;
      res.wrap_value   = wrap_q;
      res.divider_int  = div_fixed[11:4];
      res.divider_frac = div_fixed[3:0];
      res.duty_level   = level_q[14:0];
      res.tone_expired = expired;
      expected_q.push_back(res);
    endfunction

    function void check_field(string name, int unsigned want, int unsigned seen);
      if (want != seen) begin
        mismatches++;
        $display("%0t: %s differs, expected %0d, actual %0d", $time, name, want, seen);
      end
    endfunction

    function void check_result(tone_result_t got);
      tone_result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = expected_q.pop_front();
      check_field("pwm_enabled", 32'(want.pwm_enabled), 32'(got.pwm_enabled));
      check_field("pin_is_pwm", 32'(want.pin_is_pwm), 32'(got.pin_is_pwm));
      check_field("wrap_value", 32'(want.wrap_value), 32'(got.wrap_value));
      check_field("divider_int", 32'(want.divider_int), 32'(got.divider_int));
      check_field("divider_frac", 32'(want.divider_frac), 32'(got.divider_frac));
      check_field("duty_level", 32'(want.duty_level), 32'(got.duty_level));
      check_field("tone_expired", 32'(want.tone_expired), 32'(got.tone_expired));
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [27:0] cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  command;
  logic [19:0] freq_hz;
  logic [23:0] tone_len_ms;
  logic        out_valid;
  logic        out_ready;
  logic        pwm_enabled;
  logic        pin_is_pwm;
  logic [15:0] wrap_value;
  logic [7:0]  divider_int;
  logic [3:0]  divider_frac;
  logic [14:0] duty_level;
  logic        tone_expired;

  tone_scoreboard sb;
  bit             no_idling;
  int unsigned    items_sent;
  int unsigned    quiet_cycles;

  pwm_tone_setup_timer dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .freq_hz      (freq_hz),
    .tone_len_ms  (tone_len_ms),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pwm_enabled  (pwm_enabled),
    .pin_is_pwm   (pin_is_pwm),
    .wrap_value   (wrap_value),
    .divider_int  (divider_int),
    .divider_frac (divider_frac),
    .duty_level   (duty_level),
    .tone_expired (tone_expired)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Frequencies spread over the clamp edges, the audible band and the full field.
  function automatic logic [19:0] pick_freq();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 20'($urandom_range(1, 25));
      2:       return 20'($urandom_range(19990, 20010));
      3:       return 20'($urandom);
      4:       return 20'($urandom_range(200, 2000));
      default: return 20'($urandom_range(20, 20000));
    endcase
  endfunction

  function automatic logic [23:0] pick_duration();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return 24'($urandom_range(1, 30));
      2:       return 24'($urandom);
      default: return 24'hFFFFFF;
    endcase
  endfunction

  // Present one command, hold it until the block takes it, then record it.
  task automatic send_command(input logic [1:0] cmd, input logic [19:0] freq,
                              input logic [23:0] dur);
    int unsigned gap;
    gap = 0;
    if (!no_idling && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    command     <= cmd;
    freq_hz     <= freq;
    tone_len_ms <= dur;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    sb.note_command(cmd, freq, dur);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // The register is only written once every pending result has come back.
  task automatic write_sysclk(input logic [27:0] value);
    wait_drained();
    repeat (8) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    sb.sysclk_hz = value;
  endtask

  // Mostly timed tones followed by the ticks that run them out, plus noise.
  task automatic run_random(input int unsigned count);
    int unsigned target;
    int unsigned pick;
    int unsigned len;
    target = items_sent + count;
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        len = $urandom_range(1, 12);
        send_command(CMD_PLAY, pick_freq(), 24'(len));
        repeat (len) begin
          if ($urandom_range(0, 29) == 0)
            send_command(2'($urandom_range(0, 3)), pick_freq(), pick_duration());
          else
            send_command(CMD_TICK, 20'($urandom), 24'($urandom));
        end
      end else if (pick < 70) begin
        send_command(CMD_PLAY, pick_freq(), '0);
        repeat ($urandom_range(0, 3)) send_command(CMD_TICK, 20'($urandom), 24'($urandom));
        send_command(CMD_OFF, 20'($urandom), 24'($urandom));
      end else begin
        send_command(2'($urandom_range(0, 3)), pick_freq(), pick_duration());
      end
    end
    in_valid <= 1'b0;
  endtask

  // Result side: sample at the edge, then pick the ready level for the next one.
  initial begin : result_monitor
    int unsigned  stall_left;
    tone_result_t got;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        got = {pwm_enabled, pin_is_pwm, wrap_value, divider_int, divider_frac,
               duty_level, tone_expired};
        sb.check_result(got);
      end
      if (no_idling) stall_left = 0;
      else if (stall_left > 0) stall_left--;
      else if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 11);
      out_ready <= (stall_left == 0);
    end
  end

  // Watchdog: give up once no transaction has moved for too long.
  initial begin : watchdog
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  // Main sequence.
  initial begin
    sb          = new();
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    command     = CMD_TICK;
    freq_hz     = '0;
    tone_len_ms = '0;
    no_idling   = 1'b0;
    items_sent  = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed cases at the reset clock value.
    send_command(CMD_TICK, '0, '0);                    // tick with nothing armed
    send_command(CMD_OFF, '0, '0);                     // off before any play
    send_command(CMD_UNUSED, '0, '0);
    send_command(CMD_PLAY, '0, 24'd5);                 // zero frequency stops the tone and parks the pin
    send_command(CMD_PLAY, 20'd440, '0);
    send_command(CMD_PLAY, 20'd1, '0);                 // clamped up to the minimum
    send_command(CMD_PLAY, 20'd20, '0);
    send_command(CMD_PLAY, 20'd20000, '0);
    send_command(CMD_PLAY, 20'd20001, '0);             // clamped down to the maximum
    send_command(CMD_PLAY, 20'hFFFFF, 24'hFFFFFF);
    send_command(CMD_PLAY, 20'd1000, 24'd2);           // replaces the running countdown
    send_command(CMD_TICK, '0, '0);
    send_command(CMD_TICK, 20'hFFFFF, 24'hFFFFFF);     // countdown expires here
    send_command(CMD_TICK, '0, '0);
    send_command(CMD_PLAY, 20'd20000, 24'd3);
    send_command(CMD_TICK, '0, '0);
    send_command(CMD_PLAY, '0, '0);                    // zero frequency cancels the countdown
    send_command(CMD_TICK, '0, '0);
    send_command(CMD_OFF, '0, '0);
    send_command(CMD_PLAY, 20'd5000, 24'd1);
    send_command(CMD_UNUSED, 20'hFFFFF, 24'hFFFFFF);
    send_command(CMD_TICK, '0, '0);
    send_command(CMD_OFF, 20'hFFFFF, 24'hFFFFFF);
    in_valid <= 1'b0;

    // Random phases across clock settings.
    run_random(250);
    write_sysclk(28'd1000000);
    run_random(250);
    write_sysclk(28'd200000000);
    run_random(250);
    write_sysclk('0);
    run_random(150);
    write_sysclk(28'hFFFFFFF);
    run_random(250);
    write_sysclk(28'($urandom_range(1000000, 200000000)));
    run_random(250);
    write_sysclk(SYSCLK_RESET);
    run_random(200);
    write_sysclk(28'd48000000);
    no_idling = 1'b1;
    run_random(300);

    wait_drained();
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
